/* rtl/ptkf_pkg.sv */
// Shared types, constants and configuration layout of the padded tensor key filter.
package ptkf_pkg;

  localparam int unsigned MaxDims   = 4;
  localparam int unsigned LenBits   = 16;
  localparam int unsigned ValueBits = 64;
  localparam int unsigned KeyBits   = 63;
  localparam int unsigned DimBits   = 3;
  localparam int unsigned SymBits   = 8;
  localparam int unsigned AddrBits  = 6;
  localparam int unsigned DataBits  = 64;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [2:0] {
    REG_DIM_COUNT = 3'd0,
    REG_EDGE      = 3'd1,
    REG_PAD       = 3'd2,
    REG_PREPAD    = 3'd3,
    REG_SYM       = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    SYM_NONE   = 2'd0,
    SYM_SYM    = 2'd1,
    SYM_ANTI   = 2'd2,
    SYM_HOLLOW = 2'd3
  } sym_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_CHECK  = 2'd2,
    ST_EMIT   = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [KeyBits-1:0]   pair_key;
    logic [ValueBits-1:0] pair_value;
    logic                 last_pair;
  } in_item_t;

  typedef struct packed {
    logic                 keep;
    logic [KeyBits-1:0]   out_key;
    logic [ValueBits-1:0] out_value;
    logic [KeyBits-1:0]   kept_count;
    logic                 batch_end;
  } out_item_t;

  // A queued item with its front-end classification.
  typedef struct packed {
    in_item_t item;
    logic     trivial;
  } task_t;

  typedef struct packed {
    logic [DimBits-1:0]  dim_count;
    logic [63:0]         edge_lengths;
    logic [63:0]         pad_lengths;
    logic [63:0]         prepad_lengths;
    logic [SymBits-1:0]  symmetry_codes;
  } cfg_t;

endpackage

/* rtl/padded_tensor_key_filter_top.sv */
// Top level of the padded tensor key filter with its configuration registers.
//
// Items enter on a queue-style port: an item is taken when push_i is high and
// full_o is low. A two-entry queue holds accepted items for the back end.
// Results leave the same way: while empty_o is low the oldest result is on
// out_item_o, and it is taken when pop_i is high.
// Each dimension in use takes a pass through a one-bit-per-cycle divider
// shared over all dimensions that splits the key into digits; the back end
// takes the item from the queue, divides one dimension after another and
// then registers its result. It starts a new item only once that result is
// registered; a pair with a zero radix or an early out-of-range digit skips
// the remaining divisions.
// The front end keeps accepting items into its queue while the back end works
// or a result waits; when the receiver stalls, the back end holds its result
// and the queue fills, after which full_o stays high.
// Reset clears the queue, the running kept count and the configuration, with
// dimension count one. Registers sit at byte addresses 8 apart; the user must
// write configuration over the APB port only while idle, unchecked by the block.
module padded_tensor_key_filter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  ptkf_pkg::in_item_t               in_item_i,
  output logic                             empty_o,
  input  logic                             pop_i,
  output ptkf_pkg::out_item_t              out_item_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ptkf_pkg::AddrBits-1:0]    paddr,
  input  logic [ptkf_pkg::DataBits-1:0]    pwdata,
  output logic [ptkf_pkg::DataBits-1:0]    prdata,
  output logic                             pready
);

  ptkf_pkg::cfg_t  cfg_q;
  ptkf_pkg::task_t task_item;
  logic            task_valid, task_take;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_count      <= 3'd1;
      cfg_q.edge_lengths   <= '0;
      cfg_q.pad_lengths    <= '0;
      cfg_q.prepad_lengths <= '0;
      cfg_q.symmetry_codes <= '0;
    end else if (psel && penable && pwrite) begin
      case (ptkf_pkg::reg_idx_e'(reg_idx))
        ptkf_pkg::REG_DIM_COUNT: cfg_q.dim_count      <= pwdata[2:0];
        ptkf_pkg::REG_EDGE:      cfg_q.edge_lengths   <= pwdata;
        ptkf_pkg::REG_PAD:       cfg_q.pad_lengths    <= pwdata;
        ptkf_pkg::REG_PREPAD:    cfg_q.prepad_lengths <= pwdata;
        ptkf_pkg::REG_SYM:       cfg_q.symmetry_codes <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ptkf_pkg::reg_idx_e'(reg_idx))
      ptkf_pkg::REG_DIM_COUNT: prdata = 64'(cfg_q.dim_count);
      ptkf_pkg::REG_EDGE:      prdata = cfg_q.edge_lengths;
      ptkf_pkg::REG_PAD:       prdata = cfg_q.pad_lengths;
      ptkf_pkg::REG_PREPAD:    prdata = cfg_q.prepad_lengths;
      ptkf_pkg::REG_SYM:       prdata = 64'(cfg_q.symmetry_codes);
      default:                 prdata = '0;
    endcase
  end

  ptkf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .in_item_i    (in_item_i),
    .dim_count_i  (cfg_q.dim_count),
    .task_valid_o (task_valid),
    .task_o       (task_item),
    .task_take_i  (task_take)
  );

  ptkf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .task_valid_i (task_valid),
    .task_i       (task_item),
    .task_take_o  (task_take),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_item_o   (out_item_o)
  );

endmodule

/* rtl/ptkf_divider.sv */
// Radix-2 restoring divider of a 63-bit key by a 17-bit radix, one bit per cycle.
module ptkf_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptkf_pkg::KeyBits-1:0]  dividend_i,
  input  logic [ptkf_pkg::LenBits:0]    divisor_i,
  output logic                          done_o,
  output logic [ptkf_pkg::KeyBits-1:0]  quot_o,
  output logic [ptkf_pkg::LenBits:0]    rem_o
);

  logic [ptkf_pkg::KeyBits-1:0] quot_q, quot_d;
  logic [ptkf_pkg::LenBits:0]   rem_q, rem_d;
  logic [ptkf_pkg::LenBits:0]   div_q;
  logic [5:0]                   cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic [ptkf_pkg::LenBits+1:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[ptkf_pkg::KeyBits-1]};
    done_o = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'(ptkf_pkg::KeyBits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[ptkf_pkg::KeyBits-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d    = ptkf_pkg::LenBits'(0) + (ptkf_pkg::LenBits+1)'(trial - {1'b0, div_q});
        quot_d[0] = 1'b1;
      end else begin
        rem_d = (ptkf_pkg::LenBits+1)'(trial);
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) div_q <= divisor_i;
  end

  assign quot_o = quot_d;
  assign rem_o  = rem_d;

endmodule

/* rtl/ptkf_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
module ptkf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  ptkf_pkg::in_item_t         in_item_i,
  input  logic [ptkf_pkg::DimBits-1:0] dim_count_i,
  output logic                       task_valid_o,
  output ptkf_pkg::task_t            task_o,
  input  logic                       task_take_i
);

  ptkf_pkg::task_t slot_q [ptkf_pkg::FifoDepth];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == 2'(ptkf_pkg::FifoDepth));
  assign do_push      = push_i && !full_o;
  assign task_valid_o = (cnt_q != '0);
  assign do_pop       = task_take_i && task_valid_o;
  assign task_o       = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // With no dimensions in use nothing is checked and the pair is kept.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q].item    <= in_item_i;
      slot_q[wr_q].trivial <= (dim_count_i == '0);
    end
  end

endmodule

/* rtl/ptkf_back.sv */
// Back end: splits keys into digits on a shared divider, checks bounds and symmetry.
module ptkf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptkf_pkg::cfg_t               cfg_i,
  input  logic                         task_valid_i,
  input  ptkf_pkg::task_t              task_i,
  output logic                         task_take_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output ptkf_pkg::out_item_t          out_item_o
);

  localparam int unsigned L = ptkf_pkg::LenBits;

  ptkf_pkg::back_state_e state_q, state_d;
  ptkf_pkg::in_item_t    item_q;
  logic [ptkf_pkg::KeyBits-1:0] rest_q, rest_d;
  logic [L-1:0]          digit_q [ptkf_pkg::MaxDims];
  logic [1:0]            dim_q, dim_d;
  logic [2:0]            n_q;
  logic                  ok_q, ok_d;
  logic [ptkf_pkg::KeyBits-1:0] kept_q, kept_d;
  ptkf_pkg::out_item_t   out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic                  div_start, div_done;
  logic [ptkf_pkg::KeyBits-1:0] quot;
  logic [L:0]            rem;
  logic [L-1:0]          edge_f, pad_f, pre_f;
  logic [L:0]            radix;
  logic                  load_digit;
  logic                  sym_ok;
  logic                  keep;

  assign edge_f = cfg_i.edge_lengths[dim_q*L +: L];
  assign pad_f  = cfg_i.pad_lengths[dim_q*L +: L];
  assign pre_f  = cfg_i.prepad_lengths[dim_q*L +: L];
  assign radix  = {1'b0, edge_f} + {1'b0, pad_f};

  ptkf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rest_q),
    .divisor_i  (radix),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    sym_ok = 1'b1;
    for (int d = 0; d < ptkf_pkg::MaxDims - 1; d++) begin
      if (3'(d + 1) < n_q) begin
        case (ptkf_pkg::sym_e'(cfg_i.symmetry_codes[2*d +: 2]))
          ptkf_pkg::SYM_SYM: if (digit_q[d+1] < digit_q[d]) sym_ok = 1'b0;
          ptkf_pkg::SYM_ANTI, ptkf_pkg::SYM_HOLLOW:
            if (digit_q[d+1] <= digit_q[d]) sym_ok = 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    rest_d      = rest_q;
    dim_d       = dim_q;
    ok_d        = ok_q;
    kept_d      = kept_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    task_take_o = 1'b0;
    div_start   = 1'b0;
    load_digit  = 1'b0;
    keep        = 1'b0;
    if (out_valid_q && pop_i) out_valid_d = 1'b0;
    case (state_q)
      ptkf_pkg::ST_IDLE: begin
        if (task_valid_i) begin
          task_take_o = 1'b1;
          rest_d      = task_i.item.pair_key;
          dim_d       = '0;
          ok_d        = 1'b1;
          state_d     = task_i.trivial ? ptkf_pkg::ST_CHECK : ptkf_pkg::ST_DIVIDE;
          div_start   = 1'b0;
        end
      end
      ptkf_pkg::ST_DIVIDE: begin
        if (!ok_q) begin
          state_d = ptkf_pkg::ST_CHECK;
        end else if (radix == '0) begin
          ok_d    = 1'b0;
          state_d = ptkf_pkg::ST_CHECK;
        end else begin
          state_d = ptkf_pkg::ST_EMIT;
          div_start = 1'b1;
        end
      end
      ptkf_pkg::ST_EMIT: begin
        // Waiting on the divider for the current dimension.
        if (div_done) begin
          load_digit = 1'b1;
          rest_d     = quot;
          if ({1'b0, rem} >= {2'b0, edge_f} || rem < {1'b0, pre_f}) ok_d = 1'b0;
          if (3'(dim_q) + 3'd1 >= n_q) begin
            state_d = ptkf_pkg::ST_CHECK;
          end else begin
            dim_d   = dim_q + 2'd1;
            state_d = ptkf_pkg::ST_DIVIDE;
          end
        end
      end
      ptkf_pkg::ST_CHECK: begin
        if (!out_valid_d) begin
          keep             = ok_q && sym_ok;
          kept_d           = keep ? kept_q + 63'd1 : kept_q;
          out_d.keep       = keep;
          out_d.out_key    = item_q.pair_key;
          out_d.out_value  = item_q.pair_value;
          out_d.kept_count = kept_d;
          out_d.batch_end  = item_q.last_pair;
          if (item_q.last_pair) kept_d = '0;
          out_valid_d      = 1'b1;
          state_d          = ptkf_pkg::ST_IDLE;
        end
      end
      default: state_d = ptkf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptkf_pkg::ST_IDLE;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
      dim_q       <= '0;
      ok_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
      dim_q       <= dim_d;
      ok_q        <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    out_q  <= out_d;
    if (task_take_o) begin
      item_q <= task_i.item;
      n_q    <= (task_i.trivial) ? 3'd0 :
                (cfg_i.dim_count > 3'(ptkf_pkg::MaxDims)) ? 3'(ptkf_pkg::MaxDims) :
                cfg_i.dim_count;
    end
    if (load_digit) digit_q[dim_q] <= rem[L-1:0];
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule
